// ===== rtl/two_class_priority_job_queue_macros.svh =====
// Assertion macros shared by the checker of the two-class priority job queue.
`ifndef TWO_CLASS_PRIORITY_JOB_QUEUE_MACROS_SVH
`define TWO_CLASS_PRIORITY_JOB_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TCPJQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TCPJQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tcpjq_pkg.sv =====
// Types and constants of the two-class priority job queue.
`default_nettype none

package tcpjq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int SLOT_IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int ID_W        = 16;
   localparam int PAGES_W     = 16;
   localparam int CAP_W       = 5;
   localparam int OCC_W       = 5;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd10;

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;

   typedef enum logic [1:0] {
      CMD_SUBMIT  = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_FIND    = 2'd2,
      CMD_CANCEL  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_SCAN   = 2'd1,
      FSM_COMMIT = 2'd2
   } fsm_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PAGES_W-1:0] pages;
      logic               prio;
   } slot_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/tcpjq_ctrl.sv =====
// Controller state machine of the two-class priority job queue.
`default_nettype none

module tcpjq_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  tcpjq_pkg::dp_status_type dp_status,
   output tcpjq_pkg::dp_cmd_type    dp_cmd
);
   import tcpjq_pkg::*;

   fsm_type state_ff;
   fsm_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_tvalid) state_in = FSM_SCAN;
         end
         FSM_SCAN: begin
            if (dp_status.scan_done) state_in = FSM_COMMIT;
         end
         FSM_COMMIT: begin
            if (!dp_status.out_busy) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_tready       = 1'b0;
      dp_cmd.load_req  = 1'b0;
      dp_cmd.scan_step = 1'b0;
      dp_cmd.commit    = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_tready      = 1'b1;
            dp_cmd.load_req = req_tvalid;
         end
         FSM_SCAN: begin
            dp_cmd.scan_step = !dp_status.scan_done;
         end
         FSM_COMMIT: begin
            dp_cmd.commit = !dp_status.out_busy;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tcpjq_dp.sv =====
// Datapath of the two-class priority job queue: slots, counters, scan index, result register.
`default_nettype none

module tcpjq_dp (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire  [tcpjq_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire  [tcpjq_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic [tcpjq_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [tcpjq_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   input  wire                                   csr_wr_en,
   input  wire  [tcpjq_pkg::CAP_W-1:0]           csr_wr_data,
   input  tcpjq_pkg::dp_cmd_type                 dp_cmd,
   output tcpjq_pkg::dp_status_type              dp_status
);
   import tcpjq_pkg::*;

   // Slot storage, head at entry 0; no reset, only entries below the count are read.
   slot_type slot_ff [QUEUE_DEPTH];
   slot_type slot_in [QUEUE_DEPTH];

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] prio_cnt_ff, prio_cnt_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;

   cmd_type             req_cmd_ff, req_cmd_in;
   logic                req_prio_ff, req_prio_in;
   logic [PAGES_W-1:0]  req_pages_ff, req_pages_in;
   logic [ID_W-1:0]     req_target_ff, req_target_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [PAGES_W-1:0]  rsp_pages_ff, rsp_pages_in;
   logic                rsp_prio_ff, rsp_prio_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   slot_type           sel_slot;
   slot_type           new_slot;
   logic               scan_miss;
   logic               scan_match;
   logic               is_search;
   logic [COUNT_W-1:0] limit;
   logic [COUNT_W-1:0] ins_pos;
   logic [COUNT_W-1:0] rem_pos;
   logic               do_insert;
   logic               do_remove;

   assign sel_slot   = slot_ff[idx_ff[SLOT_IDX_W-1:0]];
   assign scan_miss  = (idx_ff >= count_ff);
   assign scan_match = !scan_miss && (sel_slot.id == req_target_ff);
   assign is_search  = (req_cmd_ff == CMD_FIND) || (req_cmd_ff == CMD_CANCEL);

   assign dp_status.scan_done = !is_search || scan_match || scan_miss;
   assign dp_status.out_busy  = rsp_valid_ff && !rsp_tready;

   // Effective capacity is the smaller of the register and the slot count.
   assign limit = (int'(capacity_ff) < QUEUE_DEPTH) ? COUNT_W'(capacity_ff)
                                                    : COUNT_W'(QUEUE_DEPTH);
   assign ins_pos = (req_prio_ff && (prio_cnt_ff < count_ff)) ? prio_cnt_ff : count_ff;

   assign new_slot.id    = next_id_ff;
   assign new_slot.pages = req_pages_ff;
   assign new_slot.prio  = req_prio_ff;

   always_comb begin
      slot_in       = slot_ff;
      count_in      = count_ff;
      prio_cnt_in   = prio_cnt_ff;
      next_id_in    = next_id_ff;
      capacity_in   = csr_wr_en ? csr_wr_data : capacity_ff;
      idx_in        = idx_ff;
      req_cmd_in    = req_cmd_ff;
      req_prio_in   = req_prio_ff;
      req_pages_in  = req_pages_ff;
      req_target_in = req_target_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_pages_in  = rsp_pages_ff;
      rsp_prio_in   = rsp_prio_ff;
      do_insert     = 1'b0;
      do_remove     = 1'b0;
      rem_pos       = '0;

      if (dp_cmd.load_req) begin
         req_cmd_in    = cmd_type'(req_tuser[1:0]);
         req_prio_in   = req_tuser[2];
         req_pages_in  = req_tdata[PAGES_W-1:0];
         req_target_in = req_tdata[PAGES_W +: ID_W];
         idx_in        = '0;
      end

      if (dp_cmd.scan_step) begin
         idx_in = idx_ff + COUNT_W'(1);
      end

      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
         case (req_cmd_ff)
            CMD_SUBMIT: begin
               // The id is used up even when the submit is refused.
               next_id_in  = next_id_ff + ID_W'(1);
               rsp_id_in   = next_id_ff;
               rsp_pages_in = req_pages_ff;
               rsp_prio_in = req_prio_ff;
               if (count_ff >= limit) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in = ST_OK;
                  do_insert     = 1'b1;
                  count_in      = count_ff + COUNT_W'(1);
                  if (req_prio_ff) prio_cnt_in = prio_cnt_ff + COUNT_W'(1);
               end
            end
            CMD_DEQUEUE: begin
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
                  rsp_id_in     = '0;
                  rsp_pages_in  = '0;
                  rsp_prio_in   = 1'b0;
               end else begin
                  rsp_status_in = ST_OK;
                  rsp_id_in     = slot_ff[0].id;
                  rsp_pages_in  = slot_ff[0].pages;
                  rsp_prio_in   = slot_ff[0].prio;
                  do_remove     = 1'b1;
                  rem_pos       = '0;
               end
            end
            default: begin
               // Find and cancel: the scan index rests on the first match.
               if (scan_match) begin
                  rsp_status_in = ST_OK;
                  rsp_id_in     = sel_slot.id;
                  rsp_pages_in  = sel_slot.pages;
                  rsp_prio_in   = sel_slot.prio;
                  do_remove     = (req_cmd_ff == CMD_CANCEL);
                  rem_pos       = idx_ff;
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
                  rsp_id_in     = '0;
                  rsp_pages_in  = '0;
                  rsp_prio_in   = 1'b0;
               end
            end
         endcase

         if (do_remove) begin
            count_in = count_ff - COUNT_W'(1);
            if (slot_ff[rem_pos[SLOT_IDX_W-1:0]].prio && (prio_cnt_ff != '0)) begin
               prio_cnt_in = prio_cnt_ff - COUNT_W'(1);
            end
         end
      end

      // Each slot takes its own neighbor: insertion shifts toward the tail,
      // removal closes the gap toward the head.
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (do_insert) begin
            if (COUNT_W'(i) == ins_pos) begin
               slot_in[i] = new_slot;
            end else if ((COUNT_W'(i) > ins_pos) && (i > 0)) begin
               slot_in[i] = slot_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_remove) begin
            if ((COUNT_W'(i) >= rem_pos) && (i < QUEUE_DEPTH - 1)) begin
               slot_in[i] = slot_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
         end
      end

      rsp_occ_in = dp_cmd.commit ? OCC_W'(count_in) : rsp_occ_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         prio_cnt_ff  <= '0;
         next_id_ff   <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         prio_cnt_ff  <= prio_cnt_in;
         next_id_ff   <= next_id_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      req_cmd_ff    <= req_cmd_in;
      req_prio_ff   <= req_prio_in;
      req_pages_ff  <= req_pages_in;
      req_target_ff <= req_target_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_pages_ff  <= rsp_pages_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - OCC_W - PAGES_W - ID_W)'(0),
                        rsp_occ_ff, rsp_pages_ff, rsp_id_ff};
   assign rsp_tuser  = {rsp_prio_ff, rsp_status_ff};

endmodule

`default_nettype wire

// ===== rtl/two_class_priority_job_queue.sv =====
// Top level of the two-class priority job queue: controller and datapath.
`default_nettype none
// The block keeps up to sixteen jobs in two classes: priority jobs always sit
// ahead of normal jobs, and each class is served in arrival order.
// Commands arrive as items on the req_ stream and every command returns exactly
// one item on the rsp_ stream, carrying a status, the job it concerns and the
// queue occupancy after the command.
// The csr_ port writes the capacity limit; write it only while the queue is idle.
// A submit or a dequeue passes through the scan state without a compare and is
// then committed into the output register; the next command is accepted once
// the result is registered.
// A find or a cancel compares the stored jobs one per cycle from the head, up
// to the first match or the end of the queue; the single compare port on the
// slot array is why the jobs are compared one at a time.
// Only one command is worked on at a time; req_tready is high while the
// controller waits for a new command.
// The result sits in an output register, so a new command is accepted while the
// previous result still waits; if the receiver stalls, the next command finishes
// its scan and then holds until the output register frees up.
// Reset empties the queue, restarts job ids at zero, sets the capacity limit to
// ten and drops any pending result.
module two_class_priority_job_queue (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: page_count[15:0], target_id[31:16].
   input  wire  [tcpjq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // Fields from bit 0: command[1:0], is_priority[2].
   input  wire  [tcpjq_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // Fields from bit 0: job_id[15:0], job_pages[31:16], occupancy[36:32], zeros above.
   output logic [tcpjq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Fields from bit 0: status[1:0], job_priority[2].
   output logic [tcpjq_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  wire                                csr_wr_en,
   input  wire  [tcpjq_pkg::CAP_W-1:0]        csr_wr_data
);
   import tcpjq_pkg::*;

   // Command and status groups between the controller and the datapath.
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The controller sequences load, scan and commit of each command.
   tcpjq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   // The datapath holds the slots, the counters and the result register.
   tcpjq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

endmodule

`default_nettype wire

// ===== rtl/tcpjq_checker.sv =====
// Port-level checker of the two-class priority job queue and its bind.
`default_nettype none
`include "two_class_priority_job_queue_macros.svh"

module tcpjq_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tvalid,
   input wire                                req_tready,
   input wire [tcpjq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input wire [tcpjq_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [tcpjq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire [tcpjq_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input wire                                csr_wr_en,
   input wire [tcpjq_pkg::CAP_W-1:0]         csr_wr_data
);
   import tcpjq_pkg::*;

   logic [OCC_W-1:0] occ;
   logic             unused_ok;

   assign occ       = rsp_tdata[RSP_TDATA_W-8 +: OCC_W];
   assign unused_ok = req_tvalid | req_tready | (|req_tdata) | (|req_tuser)
                      | csr_wr_en | (|csr_wr_data);

   // A stalled result stays offered.
   `TCPJQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")

   // The queue never reports more jobs than it has slots.
   `TCPJQ_ASSERT_NOW(a_occ_range, rsp_tvalid, int'(occ) <= QUEUE_DEPTH, "occupancy above depth")

   // An empty report comes only from an empty queue and carries no job.
   `TCPJQ_ASSERT_NOW(a_empty_zero, rsp_tvalid && (rsp_tuser[1:0] == ST_EMPTY), (occ == '0) && (rsp_tdata[31:0] == '0) && !rsp_tuser[2], "empty report with job data")

   // A failed search carries no job.
   `TCPJQ_ASSERT_NOW(a_miss_zero, rsp_tvalid && (rsp_tuser[1:0] == ST_NOT_FOUND), (rsp_tdata[31:0] == '0) && !rsp_tuser[2], "not-found report with job data")

endmodule

bind two_class_priority_job_queue tcpjq_checker u_tcpjq_checker (.*);

`default_nettype wire

// ===== sim/tb_two_class_priority_job_queue.sv =====
// Self-checking testbench for the two-class priority job queue.
`timescale 1ns / 1ps

// The testbench drives commands on the req_ stream, keeps its own copy of the
// queue contents and counters, and works out the expected response for every
// accepted item. Each response on the rsp_ stream is compared field by field
// with the oldest expectation. Both sides idle and stall at random, except in
// the final stretch of traffic.
module tb_two_class_priority_job_queue;
   import tcpjq_pkg::*;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 24;
   localparam int REPORT_LINES  = 40;
   localparam int PHASE_ITEMS   = 240;

   typedef struct {
      status_type         status;
      logic [ID_W-1:0]    job_id;
      logic [PAGES_W-1:0] pages;
      logic               prio;
      logic [OCC_W-1:0]   occupancy;
   } job_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // Fields from bit 0: page_count[15:0], target_id[31:16].
   logic [REQ_TDATA_W-1:0] req_tdata;
   // Fields from bit 0: command[1:0], is_priority[2].
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // Fields from bit 0: job_id[15:0], job_pages[31:16], occupancy[36:32], zeros above.
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // Fields from bit 0: status[1:0], job_priority[2].
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_wr_en;
   logic [CAP_W-1:0]       csr_wr_data;

   // Shadow copy of the queue: slot 0 is the head, priority jobs come first.
   logic [ID_W-1:0]    held_id    [QUEUE_DEPTH];
   logic [PAGES_W-1:0] held_pages [QUEUE_DEPTH];
   logic               held_prio  [QUEUE_DEPTH];
   int                 held_count;
   int                 held_prio_count;
   logic [ID_W-1:0]    next_job_id;
   logic [CAP_W-1:0]   capacity_setting;

   // Responses that were predicted but have not arrived yet, oldest first.
   job_result_type awaited_results[$];

   int mismatch_count;
   int cycle_count;
   // Random idling on both sides is on while this is set.
   bit throttle_on;

   two_class_priority_job_queue u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Removes one job from the shadow queue and closes the gap behind it.
   function automatic void drop_job(int pos);
      int i;
      if (held_prio[pos]) begin
         held_prio_count--;
      end
      for (i = pos; i + 1 < held_count; i++) begin
         held_id[i]    = held_id[i + 1];
         held_pages[i] = held_pages[i + 1];
         held_prio[i]  = held_prio[i + 1];
      end
      held_count--;
   endfunction

   // Applies one command to the shadow queue and returns the response it must produce.
   function automatic job_result_type queue_outcome(cmd_type cmd, logic prio,
                                                    logic [PAGES_W-1:0] pages,
                                                    logic [ID_W-1:0] target);
      job_result_type res;
      int limit;
      int pos;
      int i;
      res.status = ST_OK;
      res.job_id = '0;
      res.pages  = '0;
      res.prio   = 1'b0;
      limit = (int'(capacity_setting) < QUEUE_DEPTH) ? int'(capacity_setting) : QUEUE_DEPTH;
      case (cmd)
         CMD_SUBMIT: begin
            // The id is used up even when the queue refuses the job, and the
            // response echoes the submitted pages and class either way.
            res.job_id = next_job_id;
            res.pages  = pages;
            res.prio   = prio;
            next_job_id++;
            if (held_count >= limit) begin
               res.status = ST_FULL;
            end else begin
               // A priority job goes behind the last priority job, a normal job at the tail.
               pos = prio ? held_prio_count : held_count;
               for (i = held_count; i > pos; i--) begin
                  held_id[i]    = held_id[i - 1];
                  held_pages[i] = held_pages[i - 1];
                  held_prio[i]  = held_prio[i - 1];
               end
               held_id[pos]    = res.job_id;
               held_pages[pos] = pages;
               held_prio[pos]  = prio;
               held_count++;
               if (prio) begin
                  held_prio_count++;
               end
            end
         end
         CMD_DEQUEUE: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.job_id = held_id[0];
               res.pages  = held_pages[0];
               res.prio   = held_prio[0];
               drop_job(0);
            end
         end
         default: begin
            // Find and cancel act on the match nearest the head, which matters
            // once the id counter has wrapped and an id appears twice.
            pos = -1;
            for (i = held_count - 1; i >= 0; i--) begin
               if (held_id[i] == target) begin
                  pos = i;
               end
            end
            if (pos < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               res.job_id = held_id[pos];
               res.pages  = held_pages[pos];
               res.prio   = held_prio[pos];
               if (cmd == CMD_CANCEL) begin
                  drop_job(pos);
               end
            end
         end
      endcase
      res.occupancy = OCC_W'(held_count);
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
         $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      end
   endtask

   // Offers one item, waits for it to be taken, and records its expected response.
   // The valid stays high when the next item follows without a gap.
   task automatic send_command(cmd_type cmd, logic prio, logic [PAGES_W-1:0] pages,
                               logic [ID_W-1:0] target);
      int gap;
      gap = 0;
      if (throttle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {target, pages};
      req_tuser  = {prio, cmd};
      do @(posedge clock); while (!req_tready);
      awaited_results.push_back(queue_outcome(cmd, prio, pages, target));
   endtask

   // Stops sending, lets every outstanding response drain, then allows the
   // longest scan time to pass so the block is certainly at rest.
   task automatic wait_for_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] value);
      wait_for_idle();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      capacity_setting = value;
   endtask

   // Picks a command with a mix that either fills the queue or drains it.
   // Most find and cancel targets are ids that are actually queued.
   task automatic send_random_command(bit fill_mode);
      int r;
      cmd_type cmd;
      logic prio;
      logic [PAGES_W-1:0] pages;
      logic [ID_W-1:0] target;
      r = $urandom_range(0, 99);
      if (fill_mode) begin
         if (r < 55) cmd = CMD_SUBMIT;
         else if (r < 70) cmd = CMD_DEQUEUE;
         else if (r < 85) cmd = CMD_FIND;
         else cmd = CMD_CANCEL;
      end else begin
         if (r < 25) cmd = CMD_SUBMIT;
         else if (r < 55) cmd = CMD_DEQUEUE;
         else if (r < 75) cmd = CMD_FIND;
         else cmd = CMD_CANCEL;
      end
      case ($urandom_range(0, 7))
         0: pages = '0;
         1: pages = '1;
         default: pages = PAGES_W'($urandom);
      endcase
      if (held_count > 0 && $urandom_range(0, 3) != 0) begin
         target = held_id[$urandom_range(0, held_count - 1)];
      end else begin
         target = ID_W'($urandom);
      end
      prio = 1'($urandom_range(0, 1));
      send_command(cmd, prio, pages, target);
   endtask

   // Dequeue, find and cancel on an empty queue: nothing to dequeue, nothing to find or cancel.
   task automatic test_empty_queue();
      send_command(CMD_DEQUEUE, 1'b1, 16'hFFFF, 16'hFFFF);
      send_command(CMD_FIND, 1'b0, 16'h0000, 16'h0000);
      send_command(CMD_CANCEL, 1'b1, 16'hFFFF, 16'hFFFF);
   endtask

   // Mixed classes: priority jobs jump ahead of normal jobs, then cancels at the
   // middle, the tail and the head, and a final drain.
   task automatic test_class_order();
      logic [ID_W-1:0] base;
      base = next_job_id;
      send_command(CMD_SUBMIT, 1'b0, 16'h0000, 16'hFFFF);
      send_command(CMD_SUBMIT, 1'b1, 16'hFFFF, 16'h0000);
      send_command(CMD_SUBMIT, 1'b0, 16'h5A5A, 16'hA5A5);
      send_command(CMD_SUBMIT, 1'b1, 16'hA5A5, 16'h5A5A);
      send_command(CMD_FIND, 1'b0, 16'h0000, base + 16'd1);
      send_command(CMD_FIND, 1'b0, 16'h0000, base + 16'd4);
      send_command(CMD_CANCEL, 1'b0, 16'h0000, base + 16'd3);
      send_command(CMD_CANCEL, 1'b0, 16'h0000, base + 16'd2);
      send_command(CMD_CANCEL, 1'b0, 16'h0000, base + 16'd1);
      send_command(CMD_DEQUEUE, 1'b0, 16'h0000, 16'h0000);
      send_command(CMD_DEQUEUE, 1'b0, 16'h0000, 16'h0000);
   endtask

   // A small limit: a priority job appended behind another priority job at the
   // tail, then a refused submit whose id is used up and never queued.
   task automatic test_capacity_limit();
      logic [ID_W-1:0] refused_id;
      set_capacity(5'd2);
      send_command(CMD_SUBMIT, 1'b1, 16'h0001, 16'h0000);
      send_command(CMD_SUBMIT, 1'b1, 16'h0002, 16'h0000);
      refused_id = next_job_id;
      send_command(CMD_SUBMIT, 1'b0, 16'hBEEF, 16'h0000);
      send_command(CMD_FIND, 1'b0, 16'h0000, refused_id);
      send_command(CMD_CANCEL, 1'b0, 16'h0000, refused_id);
      send_command(CMD_DEQUEUE, 1'b0, 16'h0000, 16'h0000);
      send_command(CMD_DEQUEUE, 1'b0, 16'h0000, 16'h0000);
      send_command(CMD_DEQUEUE, 1'b0, 16'h0000, 16'h0000);
   endtask

   // Random traffic over several limits, the extremes among them. The command
   // mix and the idling switch every few dozen items.
   task automatic test_random_traffic();
      logic [CAP_W-1:0] limits [5];
      int phase;
      int n;
      bit fill_mode;
      limits[0] = 5'd16;
      limits[1] = 5'd1;
      limits[2] = CAP_W'($urandom_range(2, 15));
      limits[3] = CAP_W'($urandom_range(1, 16));
      limits[4] = CAPACITY_RESET;
      fill_mode = 1'b1;
      for (phase = 0; phase < 5; phase++) begin
         set_capacity(limits[phase]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) begin
               fill_mode   = 1'($urandom_range(0, 1));
               throttle_on = ($urandom_range(0, 3) != 0);
            end
            send_random_command(fill_mode);
         end
      end
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_steady_stream();
      int n;
      bit fill_mode;
      fill_mode = 1'b1;
      throttle_on = 1'b0;
      set_capacity(5'd16);
      for (n = 0; n < 200; n++) begin
         if (n % 40 == 0) begin
            fill_mode = ~fill_mode;
         end
         send_random_command(fill_mode);
      end
   endtask

   // The receiver stalls in random bursts while idling is on.
   always begin
      @(negedge clock);
      if (throttle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      rsp_tready = 1'b1;
   end

   // Every accepted response is matched against the oldest expectation.
   always @(posedge clock) begin
      job_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("item with nothing expected", {rsp_tuser, rsp_tdata[36:0]}, '0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser[1:0] !== want.status) begin
               report_mismatch("status", rsp_tuser[1:0], want.status);
            end
            if (rsp_tdata[15:0] !== want.job_id) begin
               report_mismatch("job_id", rsp_tdata[15:0], want.job_id);
            end
            if (rsp_tdata[31:16] !== want.pages) begin
               report_mismatch("job_pages", rsp_tdata[31:16], want.pages);
            end
            if (rsp_tuser[2] !== want.prio) begin
               report_mismatch("job_priority", rsp_tuser[2], want.prio);
            end
            if (rsp_tdata[36:32] !== want.occupancy) begin
               report_mismatch("occupancy", rsp_tdata[36:32], want.occupancy);
            end
         end
      end
   end

   // Watchdog: a run that hangs ends here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      int i;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      mismatch_count = 0;
      throttle_on    = 1'b1;
      for (i = 0; i < QUEUE_DEPTH; i++) begin
         held_id[i]    = '0;
         held_pages[i] = '0;
         held_prio[i]  = 1'b0;
      end
      held_count       = 0;
      held_prio_count  = 0;
      next_job_id      = '0;
      capacity_setting = CAPACITY_RESET;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_class_order();
      test_capacity_limit();
      test_random_traffic();
      test_steady_stream();
      wait_for_idle();

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
